// ===== rtl/namlp_pkg.sv =====
package namlp_pkg;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned DELTA_W    = 7;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Lookup table sizes and the constants of their formulas.
  localparam int unsigned PULSE_ENTRIES = 31;
  localparam int unsigned TND_ENTRIES   = 203;
  localparam longint unsigned PULSE_SCALE = 9552;
  localparam longint unsigned PULSE_K     = 8128;
  localparam longint unsigned TND_SCALE   = 16367;
  localparam longint unsigned TND_K       = 24329;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PULSE1_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE2_GAIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_GAIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_GAIN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_QUALITY  = 4'd7;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

  // Filter coefficients in Q0.16 and their complements.
  localparam logic [15:0] BETA_NORMAL      = 16'd39322;
  localparam logic [15:0] BETA_HQ          = 16'd52429;
  localparam logic [15:0] BETA_NORMAL_COMP = 16'd26214;
  localparam logic [15:0] BETA_HQ_COMP     = 16'd13107;

  // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2^19.
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int unsigned RECIP3_SHIFT = 19;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_P1,
    OP_P2,
    OP_TQ,
    OP_W3,
    OP_MAS,
    OP_MM,
    OP_SAT,
    OP_F1,
    OP_F2,
    OP_F3,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic filter_en;
    logic out_full;
  } dp_sts_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pulse_a_level;
    logic [LEVEL_W-1:0] pulse_b_level;
    logic [LEVEL_W-1:0] triangle_level;
    logic [LEVEL_W-1:0] noise_level;
    logic [DELTA_W-1:0] delta_level;
  } mix_item_t;

endpackage

// ===== rtl/namlp_if.sv =====
interface namlp_in_if;
  import namlp_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pulse_a_level;
  logic [LEVEL_W-1:0] pulse_b_level;
  logic [LEVEL_W-1:0] triangle_level;
  logic [LEVEL_W-1:0] noise_level;
  logic [DELTA_W-1:0] delta_level;

  modport source (output valid, pulse_a_level, pulse_b_level, triangle_level,
                  noise_level, delta_level, input ready);
  modport sink (input valid, pulse_a_level, pulse_b_level, triangle_level,
                noise_level, delta_level, output ready);
endinterface

interface namlp_out_if;
  import namlp_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface namlp_cfg_if;
  import namlp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/namlp_ctrl.sv =====
module namlp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  namlp_pkg::dp_sts_t sts,
  output namlp_pkg::dp_cmd_t cmd
);
  import namlp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_P1,
    S_P2,
    S_TQ,
    S_W3,
    S_MAS,
    S_MM,
    S_SAT,
    S_F1,
    S_F2,
    S_F3,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.op    = OP_P1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.op    = OP_P2;
        state_nxt = S_TQ;
      end
      S_TQ: begin
        cmd.op    = OP_TQ;
        state_nxt = S_W3;
      end
      S_W3: begin
        cmd.op    = OP_W3;
        state_nxt = S_MAS;
      end
      S_MAS: begin
        cmd.op    = OP_MAS;
        state_nxt = S_MM;
      end
      S_MM: begin
        cmd.op    = OP_MM;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.op    = OP_SAT;
        state_nxt = sts.filter_en ? S_F1 : S_PUSH;
      end
      S_F1: begin
        cmd.op    = OP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = OP_F2;
        state_nxt = S_F3;
      end
      S_F3: begin
        cmd.op    = OP_F3;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!sts.out_full) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (cmd.op == OP_DIV))
    else $error("accepted request did not start the mix sequence");

  a_filter_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_SAT) && sts.filter_en) |=> (cmd.op == OP_F1))
    else $error("enabled filter step was skipped");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r == (state_r == S_IDLE))
    else $error("input ready does not match the idle state");

endmodule

// ===== rtl/namlp_dp.sv =====
module namlp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  namlp_pkg::dp_cmd_t                   cmd,
  output namlp_pkg::dp_sts_t                   sts,
  input  namlp_pkg::mix_item_t                 item,
  input  logic                                 cfg_we,
  input  logic [namlp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [namlp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [namlp_pkg::SAMPLE_W-1:0]       out_sample
);
  import namlp_pkg::*;

  localparam logic [50:0] ROUND_Q29 = 51'd268435456;

  // Configuration registers.
  logic [GAIN_W-1:0] g1_r, g2_r, gt_r, gn_r, gd_r, gm_r;
  logic              fe_r, hq_r;

  // Constant lookup tables, entry 0 is zero.
  logic [14:0] pulse_rom [PULSE_ENTRIES];
  logic [15:0] tnd_rom [TND_ENTRIES];

  for (genvar gi = 0; gi < PULSE_ENTRIES; gi++) begin : g_pulse_rom
    localparam longint unsigned Num = PULSE_SCALE * gi * 65536;
    localparam longint unsigned Den = 100 * (PULSE_K + 100 * gi);
    localparam longint unsigned Ent = (gi == 0) ? 0 : (Num + Den / 2) / Den;
    assign pulse_rom[gi] = 15'(Ent);
  end

  for (genvar gi = 0; gi < TND_ENTRIES; gi++) begin : g_tnd_rom
    localparam longint unsigned Num = TND_SCALE * gi * 65536;
    localparam longint unsigned Den = 100 * (TND_K + 100 * gi);
    localparam longint unsigned Ent = (gi == 0) ? 0 : (Num + Den / 2) / Den;
    assign tnd_rom[gi] = 16'(Ent);
  end

  // Working registers.
  logic [14:0] pv_r, pb_r;
  logic [15:0] t_r;
  logic [16:0] gsp_r;
  logic [17:0] gst_r;
  logic [15:0] q_r;
  logic [1:0]  r_r;
  logic [16:0] w_r;
  logic [32:0] acc_r;
  logic [50:0] prod_r;
  logic [15:0] x_r;
  logic [15:0] prev_r;
  logic        out_valid_r;
  logic [15:0] out_sample_r;

  logic [4:0]  pulse_sum;
  logic [7:0]  tnd_idx;
  logic [32:0] mul_a;
  logic [17:0] mul_b;
  logic [50:0] mul_p;
  logic        mul_en;
  logic [32:0] half_sum;
  logic [17:0] rem_full;
  logic [16:0] w_nxt;
  logic [50:0] sat_sum;
  logic [21:0] sat_val;
  logic [15:0] sat_x;
  logic [32:0] filt_sum;

  assign pulse_sum = {1'b0, item.pulse_a_level} + {1'b0, item.pulse_b_level};
  assign tnd_idx   = {3'b0, item.triangle_level, 1'b0} + {4'b0, item.triangle_level}
                   + {3'b0, item.noise_level, 1'b0} + {1'b0, item.delta_level};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_DIV: begin
        mul_a = 33'(gst_r);
        mul_b = RECIP3;
      end
      OP_P1: begin
        mul_a = 33'(pv_r);
        mul_b = hq_r ? 18'(g1_r) : 18'(gsp_r);
      end
      OP_P2: begin
        mul_a = 33'(pb_r);
        mul_b = 18'(g2_r);
      end
      OP_TQ: begin
        mul_a = 33'(t_r);
        mul_b = 18'(q_r);
      end
      OP_W3: begin
        mul_a = 33'(w_r);
        mul_b = RECIP3;
      end
      OP_MM: begin
        mul_a = acc_r;
        mul_b = 18'(gm_r);
      end
      OP_F1: begin
        mul_a = 33'(x_r);
        mul_b = 18'(hq_r ? BETA_HQ : BETA_NORMAL);
      end
      OP_F2: begin
        mul_a = 33'(prev_r);
        mul_b = 18'(hq_r ? BETA_HQ_COMP : BETA_NORMAL_COMP);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign half_sum = 33'(prod_r[31:0]) + 33'd1;
  assign rem_full = gst_r - {1'b0, q_r, 1'b0} - {2'b0, q_r};
  assign w_nxt    = (r_r[1] ? {t_r, 1'b0} : 17'd0) + (r_r[0] ? {1'b0, t_r} : 17'd0)
                  + 17'd1;
  assign sat_sum  = prod_r + ROUND_Q29;
  assign sat_val  = sat_sum[50:29];
  assign sat_x    = (|sat_val[21:16]) ? 16'hFFFF : sat_val[15:0];
  assign filt_sum = 33'(acc_r[31:0]) + 33'(prod_r[31:0]) + 33'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r <= GAIN_UNITY;
      g2_r <= GAIN_UNITY;
      gt_r <= GAIN_UNITY;
      gn_r <= GAIN_UNITY;
      gd_r <= GAIN_UNITY;
      gm_r <= GAIN_UNITY;
      fe_r <= 1'b1;
      hq_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PULSE1_GAIN:   g1_r <= cfg_wdata;
        REG_PULSE2_GAIN:   g2_r <= cfg_wdata;
        REG_TRIANGLE_GAIN: gt_r <= cfg_wdata;
        REG_NOISE_GAIN:    gn_r <= cfg_wdata;
        REG_DELTA_GAIN:    gd_r <= cfg_wdata;
        REG_MASTER_GAIN:   gm_r <= cfg_wdata;
        REG_FILTER_ENABLE: fe_r <= cfg_wdata[0];
        REG_HIGH_QUALITY:  hq_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    case (cmd.op)
      OP_LOAD: begin
        pv_r  <= hq_r ? pulse_rom[{1'b0, item.pulse_a_level}] : pulse_rom[pulse_sum];
        pb_r  <= pulse_rom[{1'b0, item.pulse_b_level}];
        t_r   <= tnd_rom[tnd_idx];
        gsp_r <= {1'b0, g1_r} + {1'b0, g2_r};
        gst_r <= {2'b0, gt_r} + {2'b0, gn_r} + {2'b0, gd_r};
      end
      OP_P1: begin
        q_r <= prod_r[34:19];
      end
      OP_P2: begin
        acc_r <= hq_r ? 33'(prod_r[31:0]) : {1'b0, half_sum[32:1]};
        r_r   <= rem_full[1:0];
      end
      OP_TQ: begin
        acc_r <= acc_r + (hq_r ? 33'(prod_r[31:0]) : 33'd0);
        w_r   <= w_nxt;
      end
      OP_W3: begin
        acc_r <= acc_r + 33'(prod_r[31:0]);
      end
      OP_MAS: begin
        acc_r <= acc_r + 33'(prod_r[34:19]);
      end
      OP_SAT: begin
        x_r <= sat_x;
      end
      OP_F2: begin
        acc_r <= 33'(prod_r[31:0]);
      end
      OP_F3: begin
        x_r <= filt_sum[31:16];
      end
      OP_PUSH: begin
        out_sample_r <= x_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_F3) begin
        prev_r <= filt_sum[31:16];
      end
      if (cmd.op == OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.filter_en = fe_r;
  assign sts.out_full  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_TQ) |-> (r_r != 2'd3))
    else $error("division by three left a remainder of three");

  a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH) |=> (out_valid_r && (out_sample_r == $past(x_r))))
    else $error("pushed sample did not reach the output register");

  a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_F3) |=> $stable(prev_r))
    else $error("filter history changed outside the filter update");

endmodule

// ===== rtl/nonlinear_audio_mixer_lowpass.sv =====
// Five-channel nonlinear audio mixer with an optional one-pole low-pass filter.
// in_chan carries one request per sample: the two pulse levels, the triangle,
// noise and delta levels. out_chan returns one 16-bit Q1.15 sample per request.
// cfg_chan writes the gain, filter and quality registers; it is always ready
// and must only be written while no request is in flight.
// An accepted request steps through the DIV, P1, P2, TQ, W3, MAS, MM and SAT
// states, then F1 to F3 with the filter on, then PUSH; the multiplying steps
// share one 33x18 multiplier. A new request is taken from the cycle after the
// previous sample is pushed to the output register, so requests never overlap.
// Reset loads every gain with unity, enables the filter, selects normal
// quality, clears the filter history and empties the output register.
// When the receiver stalls, the finished sample waits in the output register
// while the next request is accepted and computed; that request then waits
// until the output register frees before it is pushed.
module nonlinear_audio_mixer_lowpass (
  input  logic        clk,
  input  logic        rst_n,
  namlp_in_if.sink    in_chan,
  namlp_out_if.source out_chan,
  namlp_cfg_if.sink   cfg_chan
);
  import namlp_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  mix_item_t item;
  logic      in_ready;

  // The payload is read directly off the input channel in the accept cycle.
  assign item.pulse_a_level  = in_chan.pulse_a_level;
  assign item.pulse_b_level  = in_chan.pulse_b_level;
  assign item.triangle_level = in_chan.triangle_level;
  assign item.noise_level    = in_chan.noise_level;
  assign item.delta_level    = in_chan.delta_level;
  assign in_chan.ready       = in_ready;

  // Register writes complete in the cycle they are presented.
  assign cfg_chan.ready = 1'b1;

  namlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  namlp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .item       (item),
    .cfg_we     (cfg_chan.valid),
    .cfg_idx    (cfg_chan.index),
    .cfg_wdata  (cfg_chan.data),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_sample (out_chan.sample)
  );

endmodule

// ===== test/namlp_mix_checker.sv =====
`timescale 1ns / 100ps

module namlp_mix_checker (
  input  logic  clk,
  input  logic  rst_n,
  namlp_in_if   in_mon,
  namlp_out_if  out_mon,
  namlp_cfg_if  cfg_mon,
  output int    fail_count,
  output int    pending
);
  import namlp_pkg::*;

  // Q0.16 lookup curves for the pulse pair and the triangle/noise/delta group.
  logic [16:0] pulse_curve [PULSE_ENTRIES];
  logic [16:0] tnd_curve [TND_ENTRIES];

  logic [GAIN_W-1:0]   pulse1_g, pulse2_g, triangle_g, noise_g, delta_g, master_g;
  logic                filter_on, hq_mode;
  logic [SAMPLE_W-1:0] filter_hist;
  logic [SAMPLE_W-1:0] expected_samples [$];

  longint unsigned     beta, lp_out;
  logic [SAMPLE_W-1:0] dry, want;

  // round(level / 100 * n / (k + 100 n) * 65536), zero at n = 0.
  function automatic logic [16:0] curve_entry(longint unsigned level, longint unsigned k,
                                               longint unsigned n);
    longint unsigned num;
    longint unsigned den;
    num = level * n * 64'd65536;
    den = 64'd100 * (k + 64'd100 * n);
    if (n == 0) return '0;
    return 17'((num + den / 2) / den);
  endfunction

  // Mixed sample before the low-pass filter, saturated to 16 bits.
  function automatic logic [SAMPLE_W-1:0] dry_mix(mix_item_t it);
    longint unsigned pulse_q30;
    longint unsigned tnd_q30;
    longint unsigned scaled;
    int unsigned     pidx;
    int unsigned     tidx;
    if (hq_mode) begin
      pulse_q30 = 64'(pulse_curve[it.pulse_a_level]) * 64'(pulse1_g)
                + 64'(pulse_curve[it.pulse_b_level]) * 64'(pulse2_g);
    end else begin
      pidx = 32'(it.pulse_a_level) + 32'(it.pulse_b_level);
      pulse_q30 = (64'(pulse_curve[pidx]) * (64'(pulse1_g) + 64'(pulse2_g)) + 64'd1) >> 1;
    end
    tidx = 32'd3 * 32'(it.triangle_level) + 32'd2 * 32'(it.noise_level)
         + 32'(it.delta_level);
    tnd_q30 = (64'(tnd_curve[tidx]) * (64'(triangle_g) + 64'(noise_g) + 64'(delta_g))
               + 64'd1) / 64'd3;
    scaled = ((pulse_q30 + tnd_q30) * 64'(master_g) + (64'd1 << 28)) >> 29;
    return (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    for (int n = 0; n < PULSE_ENTRIES; n++)
      pulse_curve[n] = curve_entry(PULSE_SCALE, PULSE_K, 64'(n));
    for (int n = 0; n < TND_ENTRIES; n++)
      tnd_curve[n] = curve_entry(TND_SCALE, TND_K, 64'(n));
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pulse1_g    = GAIN_UNITY;
      pulse2_g    = GAIN_UNITY;
      triangle_g  = GAIN_UNITY;
      noise_g     = GAIN_UNITY;
      delta_g     = GAIN_UNITY;
      master_g    = GAIN_UNITY;
      filter_on   = 1'b1;
      hq_mode     = 1'b0;
      filter_hist = '0;
      expected_samples.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PULSE1_GAIN:   pulse1_g   = cfg_mon.data;
          REG_PULSE2_GAIN:   pulse2_g   = cfg_mon.data;
          REG_TRIANGLE_GAIN: triangle_g = cfg_mon.data;
          REG_NOISE_GAIN:    noise_g    = cfg_mon.data;
          REG_DELTA_GAIN:    delta_g    = cfg_mon.data;
          REG_MASTER_GAIN:   master_g   = cfg_mon.data;
          REG_FILTER_ENABLE: filter_on  = cfg_mon.data[0];
          REG_HIGH_QUALITY:  hq_mode    = cfg_mon.data[0];
          default: ;
        endcase
      end

      // Results leave before the request of the same edge is predicted.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample: unexpected result %0d with no request outstanding",
                 out_mon.sample);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, out_mon.sample);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        dry = dry_mix('{in_mon.pulse_a_level, in_mon.pulse_b_level, in_mon.triangle_level,
                        in_mon.noise_level, in_mon.delta_level});
        if (filter_on) begin
          beta = hq_mode ? 64'(BETA_HQ) : 64'(BETA_NORMAL);
          lp_out = (beta * 64'(dry) + (64'd65536 - beta) * 64'(filter_hist) + 64'd32768) >> 16;
          if (lp_out > 64'd65535) lp_out = 64'd65535;
          filter_hist = lp_out[15:0];
          expected_samples.push_back(lp_out[15:0]);
        end else begin
          expected_samples.push_back(dry);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== test/nonlinear_audio_mixer_lowpass_test.sv =====
`timescale 1ns / 100ps

// Top of the mixer testbench. This module only generates traffic and gives
// the verdict; all prediction and comparison lives in namlp_mix_checker,
// which sits beside the block and watches all three channels.
module nonlinear_audio_mixer_lowpass_test;
  import namlp_pkg::*;

  // Three directed phases are followed by twelve random ones. Each phase
  // after the first begins with a fresh register setting, written only once
  // the block has drained every outstanding request.
  localparam int PHASES           = 15;
  localparam int DIRECTED_PHASES  = 3;
  localparam int RANDOM_PER_PHASE = 108;
  localparam int HOLD_PHASE       = 7;

  // The quiet period outlasts the block's path from acceptance to a valid
  // sample, so it is enough to be sure nothing is still in flight.
  localparam int SETTLE_CYCLES = 16;

  // Length of the deliberate receiver stall that backs the block up.
  localparam int HOLD_CYCLES = 400;

  // The longest legal stretch without any handshake is the deliberate
  // receiver stall plus one request's latency, and random gaps are far
  // shorter. The watchdog allows ten times the stall.
  localparam int WATCHDOG_LIMIT = 4000;

  // An index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;

  typedef struct packed {
    logic [GAIN_W-1:0] pulse1, pulse2, triangle, noise, delta, master;
    logic              filter_en;
    logic              hq;
  } mixer_cfg_t;

  logic clk;
  logic rst_n;

  namlp_in_if  in_chan ();
  namlp_out_if out_chan ();
  namlp_cfg_if cfg_chan ();

  int fails;
  int pending;

  // Percentage of cycles in which the sender or the receiver holds back.
  int src_idle  = 0;
  int sink_idle = 0;

  // Raised by the stimulus to ask the receiver for one long stall.
  bit hold_sink = 1'b0;

  mixer_cfg_t mix_cfg;
  mix_item_t  item;

  // Corner requests: silence, every channel at full scale, each pulse alone,
  // the tnd index at its top, two alternating bit patterns that between them
  // toggle every input bit, and the combined pulse index at its top.
  mix_item_t directed_mixes [8] = '{
    '{4'd0,  4'd0,  4'd0,  4'd0,  7'd0},
    '{4'd15, 4'd15, 4'd15, 4'd15, 7'd127},
    '{4'd15, 4'd0,  4'd0,  4'd0,  7'd0},
    '{4'd0,  4'd15, 4'd0,  4'd0,  7'd0},
    '{4'd0,  4'd0,  4'd15, 4'd15, 7'd127},
    '{4'd5,  4'd10, 4'd10, 4'd5,  7'd85},
    '{4'd10, 4'd5,  4'd5,  4'd10, 7'd42},
    '{4'd15, 4'd15, 4'd0,  4'd0,  7'd0}
  };

  nonlinear_audio_mixer_lowpass u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  namlp_mix_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gains are drawn so that the extremes and the region around unity show
  // up often, with plain random values for the rest.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1:       return 16'(int'(GAIN_UNITY) + $urandom_range(512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted. Before
  // the offer the sender idles cycle by cycle at the current idle rate. The
  // valid line is left high so that a back-to-back request needs no second
  // assignment in the same step; it drops only when the sender idles or the stream stops.
  task automatic send_mix(input mix_item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.pulse_a_level  <= it.pulse_a_level;
    in_chan.pulse_b_level  <= it.pulse_b_level;
    in_chan.triangle_level <= it.triangle_level;
    in_chan.noise_level    <= it.noise_level;
    in_chan.delta_level    <= it.delta_level;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  // Stops the request stream, lets the block drain, and writes every
  // register. The one-bit registers get random upper bits, which the block
  // must drop, and a write to an unused index must change nothing.
  task automatic configure(input mixer_cfg_t c);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_PULSE1_GAIN, c.pulse1);
    write_reg(REG_PULSE2_GAIN, c.pulse2);
    write_reg(REG_TRIANGLE_GAIN, c.triangle);
    write_reg(REG_NOISE_GAIN, c.noise);
    write_reg(REG_DELTA_GAIN, c.delta);
    write_reg(REG_MASTER_GAIN, c.master);
    write_reg(REG_FILTER_ENABLE, {15'($urandom), c.filter_en});
    write_reg(REG_HIGH_QUALITY, {15'($urandom), c.hq});
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_chan.valid <= 1'b0;
  endtask

  // Receiver: random backpressure at the current idle rate, plus one long
  // stall on request. The stall is counted here so that the sender keeps
  // offering requests and the block fills up behind the held sample.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_chan.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL nonlinear_audio_mixer_lowpass");
    $finish;
  end

  initial begin
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.pulse_a_level  <= '0;
    in_chan.pulse_b_level  <= '0;
    in_chan.triangle_level <= '0;
    in_chan.noise_level    <= '0;
    in_chan.delta_level    <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.index         <= REG_PULSE1_GAIN;
    cfg_chan.data          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      // The first third idles mostly on the receiver, the second third
      // mostly on the sender, and the last third runs at full speed.
      if (ph < 5) begin
        src_idle  = 36;
        sink_idle = 53;
      end else if (ph < 10) begin
        src_idle  = 53;
        sink_idle = 36;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end

      // Phase 0 runs on the reset values: unity gains, filter on, normal
      // quality. Phase 1 drives every gain to full scale with the filter off
      // so the output saturates; phase 2 does the same in high-quality mode
      // through the filter; phase 3 zeroes every gain.
      if (ph == 1) begin
        mix_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0};
      end else if (ph == 2) begin
        mix_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1};
      end else if (ph == 3) begin
        mix_cfg = '0;
        mix_cfg.filter_en = 1'($urandom);
        mix_cfg.hq        = 1'($urandom);
      end else begin
        mix_cfg.pulse1    = pick_gain();
        mix_cfg.pulse2    = pick_gain();
        mix_cfg.triangle  = pick_gain();
        mix_cfg.noise     = pick_gain();
        mix_cfg.delta     = pick_gain();
        mix_cfg.master    = pick_gain();
        mix_cfg.filter_en = 1'($urandom);
        mix_cfg.hq        = 1'($urandom);
      end
      if (ph != 0) configure(mix_cfg);

      if (ph == HOLD_PHASE) hold_sink = 1'b1;

      if (ph < DIRECTED_PHASES) begin
        foreach (directed_mixes[i]) send_mix(directed_mixes[i]);
      end else begin
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
          // One request in ten puts every channel at silence or full scale;
          // the rest are uniform over each level's range.
          if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) item = '1;
            else item = '0;
          end else begin
            item.pulse_a_level  = 4'($urandom);
            item.pulse_b_level  = 4'($urandom);
            item.triangle_level = 4'($urandom);
            item.noise_level    = 4'($urandom);
            item.delta_level    = 7'($urandom);
          end
          send_mix(item);
        end
      end
    end

    // Drain: wait for every predicted sample, then a short quiet period so a
    // stray extra result would still be caught.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0)
      $display("PASS nonlinear_audio_mixer_lowpass");
    else
      $display("FAIL nonlinear_audio_mixer_lowpass");
    $finish;
  end

endmodule
